[src/lzwc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants for the fixed-width LZW byte compressor.
// ---------------------------------------------------------------------------
package lzwc_pkg;

  localparam int CODE_BITS  = 12;
  localparam int DICT_DEPTH = 1 << CODE_BITS;
  localparam int ROOT_CODES = 256;
  localparam int SH_W       = CODE_BITS + 7;
  localparam int CNT_W      = $clog2(SH_W + 1);

  typedef logic [CODE_BITS-1:0] code_t;

  localparam code_t CLEAR_CODE = code_t'(DICT_DEPTH - 1);
  localparam code_t ROOT_FIRST = code_t'(ROOT_CODES);

  // one queued input item, already classified
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_end;
  } item_t;

  // queue to engine handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FULL,
    ST_FULL_CLR,
    ST_EMIT,
    ST_END_CHK,
    ST_FLUSH,
    ST_FIN
  } state_t;

endpackage

[src/lzwc_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzwc channel interfaces
// Valid/ready channels for input items and packed output bytes.
// ---------------------------------------------------------------------------
interface lzwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_stream;
  modport source (output valid, data_byte, byte_present, end_of_stream, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_stream, output ready);
endinterface

interface lzwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;
  modport source (output valid, out_byte, last_of_run, stream_done, input ready);
  modport sink   (input valid, out_byte, last_of_run, stream_done, output ready);
endinterface

[src/lzwc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzwc_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module lzwc_front (
  input  logic                clk,
  input  logic                rst_n,
  lzwc_in_if.sink             in_ch,
  output lzwc_pkg::queue_out_t q_out,
  input  logic                q_pop
);

  lzwc_pkg::item_t slot_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  logic            pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && (cnt_r != 2'd0);

  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.item  = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store the classified item on each transfer
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r].data_byte <= in_ch.data_byte;
      slot_r[wr_ptr_r].has_byte  <= in_ch.byte_present;
      slot_r[wr_ptr_r].is_end    <= in_ch.end_of_stream;
    end
  end

endmodule

[src/lzwc_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzwc_engine
// Dictionary search, code emission, bit packing and output register.
// ---------------------------------------------------------------------------
module lzwc_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzwc_pkg::queue_out_t q_in,
  output logic                 q_pop,
  lzwc_out_if.source           out_ch
);

  // dictionary: {prefix, char} per code
  logic [lzwc_pkg::CODE_BITS+7:0] dict_mem [lzwc_pkg::DICT_DEPTH];
  logic [lzwc_pkg::CODE_BITS+7:0] rd_q;
  logic                           dict_we;

  lzwc_pkg::state_t  state_r, state_nxt, ret_r, ret_nxt;
  lzwc_pkg::code_t   next_free_r, next_free_nxt;
  lzwc_pkg::code_t   pending_r, pending_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic [2:0]        bits_r, bits_nxt;
  lzwc_pkg::code_t   idx_r, idx_nxt;
  logic [7:0]        chr_r, chr_nxt;
  logic              end_r, end_nxt;
  logic [lzwc_pkg::SH_W-1:0]  sh_r, sh_nxt;
  logic [lzwc_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              held_v_r, held_v_nxt;
  logic              ov_r, ov_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              od_r, od_nxt;
  logic              out_free;
  logic              can_put;
  logic              emit_more;
  logic              hit;

  assign out_free  = !ov_r || out_ch.ready;
  assign can_put   = !held_v_r || out_free;
  assign emit_more = (n_r >= lzwc_pkg::CNT_W'(8));
  assign hit       = (rd_q == {pending_r, chr_r});

  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = ob_r;
  assign out_ch.last_of_run = ol_r;
  assign out_ch.stream_done = od_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzwc_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          if (!q_in.item.has_byte)  state_nxt = lzwc_pkg::ST_END_CHK;
          else if (!pend_v_r)       state_nxt = lzwc_pkg::ST_FULL;
          else                      state_nxt = lzwc_pkg::ST_SRCH_RD;
        end
      end
      lzwc_pkg::ST_SRCH_RD:
        state_nxt = (idx_r >= next_free_r) ? lzwc_pkg::ST_EMIT : lzwc_pkg::ST_SRCH_CMP;
      lzwc_pkg::ST_SRCH_CMP:
        state_nxt = hit ? lzwc_pkg::ST_FULL : lzwc_pkg::ST_SRCH_RD;
      lzwc_pkg::ST_FULL:
        state_nxt = (next_free_r >= lzwc_pkg::CLEAR_CODE) ? lzwc_pkg::ST_EMIT
                                                           : lzwc_pkg::ST_END_CHK;
      lzwc_pkg::ST_FULL_CLR: state_nxt = lzwc_pkg::ST_EMIT;
      lzwc_pkg::ST_EMIT: begin
        if (!emit_more) state_nxt = ret_r;
      end
      lzwc_pkg::ST_END_CHK:
        state_nxt = (end_r && pend_v_r) ? lzwc_pkg::ST_EMIT : lzwc_pkg::ST_FLUSH;
      lzwc_pkg::ST_FLUSH: begin
        if (!(end_r && bits_r != 3'd0) || can_put) state_nxt = lzwc_pkg::ST_FIN;
      end
      lzwc_pkg::ST_FIN: begin
        if (!held_v_r || out_free) state_nxt = lzwc_pkg::ST_IDLE;
      end
      default: state_nxt = lzwc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ret_nxt       = ret_r;
    next_free_nxt = next_free_r;
    pending_nxt   = pending_r;
    pend_v_nxt    = pend_v_r;
    acc_nxt       = acc_r;
    bits_nxt      = bits_r;
    idx_nxt       = idx_r;
    chr_nxt       = chr_r;
    end_nxt       = end_r;
    sh_nxt        = sh_r;
    n_nxt         = n_r;
    held_nxt      = held_r;
    held_v_nxt    = held_v_r;
    ov_nxt        = ov_r && !out_ch.ready;
    ob_nxt        = ob_r;
    ol_nxt        = ol_r;
    od_nxt        = od_r;
    q_pop         = 1'b0;
    dict_we       = 1'b0;
    case (state_r)
      lzwc_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          q_pop   = 1'b1;
          chr_nxt = q_in.item.data_byte;
          end_nxt = q_in.item.is_end;
          idx_nxt = lzwc_pkg::ROOT_FIRST;
          if (q_in.item.has_byte && !pend_v_r) begin
            pending_nxt = lzwc_pkg::code_t'(q_in.item.data_byte);
            pend_v_nxt  = 1'b1;
          end
        end
      end
      lzwc_pkg::ST_SRCH_RD: begin
        // no match: add entry, send the old string, restart at this byte
        if (idx_r >= next_free_r) begin
          dict_we       = 1'b1;
          next_free_nxt = next_free_r + 1'b1;
          sh_nxt        = lzwc_pkg::SH_W'(acc_r) | (lzwc_pkg::SH_W'(pending_r) << bits_r);
          n_nxt         = lzwc_pkg::CNT_W'(bits_r) + lzwc_pkg::CNT_W'(lzwc_pkg::CODE_BITS);
          pending_nxt   = lzwc_pkg::code_t'(chr_r);
          ret_nxt       = lzwc_pkg::ST_FULL;
        end
      end
      lzwc_pkg::ST_SRCH_CMP: begin
        if (hit) pending_nxt = idx_r;
        else     idx_nxt     = idx_r + 1'b1;
      end
      lzwc_pkg::ST_FULL: begin
        // dictionary full: send pending, then the clear code
        if (next_free_r >= lzwc_pkg::CLEAR_CODE) begin
          sh_nxt      = lzwc_pkg::SH_W'(acc_r) | (lzwc_pkg::SH_W'(pending_r) << bits_r);
          n_nxt       = lzwc_pkg::CNT_W'(bits_r) + lzwc_pkg::CNT_W'(lzwc_pkg::CODE_BITS);
          pend_v_nxt  = 1'b0;
          pending_nxt = '0;
          ret_nxt     = lzwc_pkg::ST_FULL_CLR;
        end
      end
      lzwc_pkg::ST_FULL_CLR: begin
        sh_nxt        = lzwc_pkg::SH_W'(acc_r)
                        | (lzwc_pkg::SH_W'(lzwc_pkg::CLEAR_CODE) << bits_r);
        n_nxt         = lzwc_pkg::CNT_W'(bits_r) + lzwc_pkg::CNT_W'(lzwc_pkg::CODE_BITS);
        next_free_nxt = lzwc_pkg::ROOT_FIRST;
        ret_nxt       = lzwc_pkg::ST_END_CHK;
      end
      lzwc_pkg::ST_EMIT: begin
        // peel whole bytes off the shifter, keep the remainder
        if (emit_more) begin
          if (can_put) begin
            if (held_v_r) begin
              ov_nxt = 1'b1;
              ob_nxt = held_r;
              ol_nxt = 1'b0;
              od_nxt = 1'b0;
            end
            held_nxt   = sh_r[7:0];
            held_v_nxt = 1'b1;
            sh_nxt     = sh_r >> 8;
            n_nxt      = n_r - lzwc_pkg::CNT_W'(8);
          end
        end else begin
          acc_nxt  = sh_r[7:0];
          bits_nxt = n_r[2:0];
        end
      end
      lzwc_pkg::ST_END_CHK: begin
        if (end_r && pend_v_r) begin
          sh_nxt  = lzwc_pkg::SH_W'(acc_r) | (lzwc_pkg::SH_W'(pending_r) << bits_r);
          n_nxt   = lzwc_pkg::CNT_W'(bits_r) + lzwc_pkg::CNT_W'(lzwc_pkg::CODE_BITS);
          ret_nxt = lzwc_pkg::ST_FLUSH;
        end
      end
      lzwc_pkg::ST_FLUSH: begin
        if (end_r && bits_r != 3'd0 && can_put) begin
          if (held_v_r) begin
            ov_nxt = 1'b1;
            ob_nxt = held_r;
            ol_nxt = 1'b0;
            od_nxt = 1'b0;
          end
          held_nxt   = acc_r;
          held_v_nxt = 1'b1;
          acc_nxt    = '0;
          bits_nxt   = '0;
        end
      end
      lzwc_pkg::ST_FIN: begin
        // last byte of the item goes out marked
        if (!held_v_r || out_free) begin
          if (held_v_r) begin
            ov_nxt     = 1'b1;
            ob_nxt     = held_r;
            ol_nxt     = 1'b1;
            od_nxt     = end_r;
            held_v_nxt = 1'b0;
          end
          if (end_r) begin
            next_free_nxt = lzwc_pkg::ROOT_FIRST;
            pending_nxt   = '0;
            pend_v_nxt    = 1'b0;
            acc_nxt       = '0;
            bits_nxt      = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzwc_pkg::ST_IDLE;
      ret_r       <= lzwc_pkg::ST_IDLE;
      next_free_r <= lzwc_pkg::ROOT_FIRST;
      pending_r   <= '0;
      pend_v_r    <= 1'b0;
      acc_r       <= '0;
      bits_r      <= '0;
      held_v_r    <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      next_free_r <= next_free_nxt;
      pending_r   <= pending_nxt;
      pend_v_r    <= pend_v_nxt;
      acc_r       <= acc_nxt;
      bits_r      <= bits_nxt;
      held_v_r    <= held_v_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    chr_r  <= chr_nxt;
    end_r  <= end_nxt;
    sh_r   <= sh_nxt;
    n_r    <= n_nxt;
    held_r <= held_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    od_r   <= od_nxt;
  end

  // dictionary memory, registered read
  always_ff @(posedge clk) begin
    if (dict_we) dict_mem[next_free_r] <= {pending_r, chr_r};
    rd_q <= dict_mem[idx_r];
  end

endmodule

[src/lzw_byte_compressor.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzw_byte_compressor
// LZW compressor with fixed 12-bit codes packed LSB first into bytes.
// ---------------------------------------------------------------------------
// Each input item carries an optional byte and an end-of-stream flag; each
// result is one packed output byte, the last of an item flagged last_of_run
// and the last byte of a stream flagged stream_done. A byte is
// matched against the dictionary by scanning entries 256 up to the next free
// code through a memory with a registered read, reading and then comparing
// each entry in turn; for a byte that follows a pending string, the scan
// dominates its cost, and a stalled sink adds its stall. A two-entry input
// queue lets items arrive while the engine works, and an output register
// holds a byte while the sink stalls.
// After an end-of-stream item the block starts a fresh stream.
module lzw_byte_compressor (
  input  logic        clk,
  input  logic        rst_n,
  lzwc_in_if.sink     in_ch,
  lzwc_out_if.source  out_ch
);

  lzwc_pkg::queue_out_t q;
  logic                 q_pop;

  // front: accept and queue items
  lzwc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_out (q),
    .q_pop (q_pop)
  );

  // back: search, emit and pack
  lzwc_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_in   (q),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

[tb/sv/tb_lzw_byte_compressor.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lzw_byte_compressor
// Self-checking bench for the fixed-width LZW byte compressor.
// ---------------------------------------------------------------------------
// A queue of byte/end items feeds a valid/ready driver. Each accepted
// transfer runs through a behavioural LZW encoder with its own dictionary
// and bit packer. The packed bytes it predicts are queued and then checked
// field by field against the output channel. Both sides of the handshake
// idle at random in the first two phases; the third phase has no idling.
// The output side also holds off for a long stretch, and the input side
// pauses after each phase until the output side has drained.
module tb_lzw_byte_compressor;

  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_stream;
  } lzw_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lzwc_in_if  in_if ();
  lzwc_out_if out_if ();

  lzw_byte_compressor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #2 clk = ~clk;

  lzw_item_t    items_to_send[$];
  packed_byte_t bytes_due[$];
  int           send_idle_pct = 17;
  int           recv_idle_pct = 51;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  int           errors = 0;
  int           cycles = 0;

  // encoder state
  lzwc_pkg::code_t enc_pfx [lzwc_pkg::DICT_DEPTH];
  logic [7:0]      enc_chr [lzwc_pkg::DICT_DEPTH];
  int unsigned     enc_next;
  lzwc_pkg::code_t enc_pend;
  bit              enc_pend_ok;
  logic [7:0]      enc_acc;
  int unsigned     enc_bits;
  logic [7:0]      run_bytes[$];

  task automatic encoder_reset();
    enc_next    = lzwc_pkg::ROOT_CODES;
    enc_pend    = '0;
    enc_pend_ok = 1'b0;
    enc_acc     = '0;
    enc_bits    = 0;
  endtask

  task automatic pack_code(input lzwc_pkg::code_t code);
    logic [31:0] acc;
    int unsigned n;
    acc = {24'd0, enc_acc} | (32'(code) << enc_bits);
    n   = enc_bits + lzwc_pkg::CODE_BITS;
    while (n >= 8) begin
      run_bytes = {run_bytes, acc[7:0]};
      acc = acc >> 8;
      n   = n - 8;
    end
    enc_acc  = acc[7:0];
    enc_bits = n;
  endtask

  task automatic encode_byte(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    if (!enc_pend_ok) begin
      enc_pend    = lzwc_pkg::code_t'(c);
      enc_pend_ok = 1'b1;
    end else begin
      for (int unsigned i = lzwc_pkg::ROOT_CODES;
           i < enc_next && i < lzwc_pkg::DICT_DEPTH; i++) begin
        if (!hit && enc_pfx[i] == enc_pend && enc_chr[i] == c) begin
          enc_pend = lzwc_pkg::code_t'(i);
          hit      = 1'b1;
        end
      end
      if (!hit) begin
        if (enc_next < lzwc_pkg::DICT_DEPTH) begin
          enc_pfx[enc_next] = enc_pend;
          enc_chr[enc_next] = c;
        end
        enc_next++;
        pack_code(enc_pend);
        enc_pend = lzwc_pkg::code_t'(c);
      end
    end
    // dictionary full: flush pending, send clear, start over
    if (enc_next >= lzwc_pkg::CLEAR_CODE) begin
      pack_code(enc_pend);
      enc_pend_ok = 1'b0;
      enc_pend    = '0;
      pack_code(lzwc_pkg::CLEAR_CODE);
      enc_next    = lzwc_pkg::ROOT_CODES;
    end
  endtask

  task automatic predict_transfer(input lzw_item_t it);
    packed_byte_t pb;
    run_bytes.delete();
    if (it.byte_present) encode_byte(it.data_byte);
    if (it.end_of_stream) begin
      if (enc_pend_ok) pack_code(enc_pend);
      if (enc_bits != 0) begin
        run_bytes = {run_bytes, enc_acc};
        enc_bits = 0;
        enc_acc  = '0;
      end
    end
    foreach (run_bytes[i]) begin
      pb.out_byte    = run_bytes[i];
      pb.last_of_run = (i == run_bytes.size() - 1);
      pb.stream_done = pb.last_of_run && it.end_of_stream;
      bytes_due = {bytes_due, pb};
    end
    if (it.end_of_stream) encoder_reset();
  endtask

  // input driver
  always @(posedge clk) begin
    lzw_item_t nxt;
    if (!rst_n) begin
      in_if.valid         <= 1'b0;
      in_if.data_byte     <= '0;
      in_if.byte_present  <= 1'b0;
      in_if.end_of_stream <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        predict_transfer({in_if.data_byte, in_if.byte_present, in_if.end_of_stream});
      if (!in_if.valid || in_if.ready) begin
        if (items_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = items_to_send.pop_front();
          in_if.valid         <= 1'b1;
          in_if.data_byte     <= nxt.data_byte;
          in_if.byte_present  <= nxt.byte_present;
          in_if.end_of_stream <= nxt.end_of_stream;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off, counted here
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= 600;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // output ready and result check
  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual byte=%02h last=%b done=%b",
                   $time, out_if.out_byte, out_if.last_of_run, out_if.stream_done);
          errors++;
        end else begin
          want = bytes_due.pop_front();
          if (out_if.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     want.out_byte, out_if.out_byte);
            errors++;
          end
          if (out_if.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b actual %b", $time,
                     want.last_of_run, out_if.last_of_run);
            errors++;
          end
          if (out_if.stream_done !== want.stream_done) begin
            $display("%0t: stream_done expected %b actual %b", $time,
                     want.stream_done, out_if.stream_done);
            errors++;
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** lzw_byte_compressor: FAILED **");
      $finish;
    end
  end

  task automatic add_item(input logic [7:0] b, input bit present, input bit fin);
    items_to_send = {items_to_send, lzw_item_t'({b, present, fin})};
  endtask

  // one stream of random length; narrow alphabets give dictionary hits
  task automatic add_stream(input int len);
    int unsigned base;
    int unsigned span;
    logic [7:0] b;
    base = $urandom_range(0, 255);
    span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      b = 8'(base + $urandom_range(0, span));
      if ($urandom_range(0, 19) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1) begin
        // end carried on the last byte or as a separate end-only item
        if ($urandom_range(0, 1) == 1) add_item(b, 1'b1, 1'b1);
        else begin
          add_item(b, 1'b1, 1'b0);
          add_item(8'($urandom), 1'b0, 1'b1);
        end
      end else begin
        add_item(b, 1'b1, 1'b0);
      end
    end
  endtask

  task automatic add_random(input int n);
    int len;
    while (n > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 25);
      if (len > n) len = n;
      add_stream(len);
      n -= len;
    end
  endtask

  task automatic wait_drained();
    while (items_to_send.size() != 0 || in_if.valid || bytes_due.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    encoder_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: end with nothing, idle, extremes, single bytes, repeats
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 8; i++) add_item(8'h41, 1'b1, 1'b0);
    add_item(8'h55, 1'b1, 1'b0);
    add_item(8'haa, 1'b1, 1'b0);
    add_item(8'h41, 1'b1, 1'b0);
    add_item(8'h41, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h7f, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);

    // phase one: sender idles rarely, receiver often
    add_random(110);
    wait_drained();

    // phase two: the other way round, with a long output hold-off
    send_idle_pct = 51;
    recv_idle_pct = 17;
    hold_req      = 1'b1;
    add_random(110);
    repeat (2) @(posedge clk);
    hold_req      = 1'b0;
    wait_drained();

    // phase three: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(100);
    wait_drained();
    repeat (200) @(posedge clk);

    if (errors == 0 && bytes_due.size() == 0) begin
      $display("** lzw_byte_compressor: PASSED **");
    end else begin
      $display("** lzw_byte_compressor: FAILED **");
    end
    $finish;
  end

endmodule
